FILE: rtl/core/ntpr_pkg.sv
// ntpr_pkg: types, constants and helpers for the note to pad router
// shared by ntpr_tables and note_to_pad_router_with_learn_unit; no dependencies
package ntpr_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int NOTE_W     = 7;
  localparam int PAD_W      = 4;
  localparam int PAD_COUNT  = 16;
  localparam int PAD_IDX_W  = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam logic [7:0] PAD_LIMIT = 8'(PAD_COUNT);

  typedef enum logic [1:0] {
    CMD_NOTE_ON = 2'd0,
    CMD_ARM     = 2'd1,
    CMD_CANCEL  = 2'd2,
    CMD_ASSIGN  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [NOTE_W-1:0] note;
    logic [PAD_W-1:0]  pad;
  } req_t;

  typedef struct packed {
    logic [PAD_W-1:0] pad_out;
    logic             pad_valid;
    logic             learned;
    logic             learn_armed;
  } rsp_t;

  // registered read data of both tables, valid in the cycle after the read
  typedef struct packed {
    logic              note_vld;
    logic [PAD_W-1:0]  note_pad;
    logic              pad_vld;
    logic [NOTE_W-1:0] pad_note;
  } tbl_rd_t;

  // bind write plus the clears of stale partners
  typedef struct packed {
    logic              en;
    logic [NOTE_W-1:0] note;
    logic [PAD_W-1:0]  pad;
    logic              clr_note_en;
    logic [NOTE_W-1:0] clr_note;
    logic              clr_pad_en;
    logic [PAD_W-1:0]  clr_pad;
  } tbl_wr_t;

  // pad number is within the configured pad range
  function automatic logic pad_ok(input logic [PAD_W-1:0] p);
    return 8'(p) < PAD_LIMIT;
  endfunction

  // pad number to pad table index
  function automatic logic [PAD_IDX_W-1:0] pad_idx(input logic [PAD_W-1:0] p);
    logic [PAD_IDX_W+PAD_W-1:0] ext;
    ext = {{PAD_IDX_W{1'b0}}, p};
    return ext[PAD_IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/core/note_to_pad_router_with_learn_unit.sv
// note_to_pad_router_with_learn_unit: no new item is taken while busy; busy is
// high in the cycle after an accept, while the table read data is used
// and the bind is written back. done pulses in the cycle after busy; the
// receiver cannot stall. Synchronous reset empties both tables at once via
// valid flops and disarms learn capture.
module note_to_pad_router_with_learn_unit
  import ntpr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  req_t             item;
  logic [PAD_W-1:0] bind_pad;
  logic             learn_active;
  logic [PAD_W-1:0] learn_target;
  logic             learn_active_next;
  logic [PAD_W-1:0] learn_target_next;
  logic             accept;
  logic             learn_hit;
  logic             do_bind;
  tbl_rd_t          rd;
  tbl_wr_t          wr;
  rsp_t             rsp_next;

  assign accept = start && !busy;

  // latch the item and the pad it would bind to
  always_ff @(posedge clk) begin
    if (accept) begin
      item     <= req;
      bind_pad <= (req.cmd == CMD_ASSIGN) ? req.pad : learn_target;
    end
  end

  ntpr_tables u_tables (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_note (req.note),
    .rd_pad  ((req.cmd == CMD_ASSIGN) ? req.pad : learn_target),
    .rd      (rd),
    .wr      (wr)
  );

  // decide the bind and the learn state update
  always_comb begin
    learn_hit         = (item.cmd == CMD_NOTE_ON) && learn_active && pad_ok(learn_target);
    do_bind           = learn_hit || ((item.cmd == CMD_ASSIGN) && pad_ok(item.pad));
    learn_active_next = learn_active;
    learn_target_next = learn_target;
    case (item.cmd)
      CMD_NOTE_ON: if (learn_hit) learn_active_next = 1'b0;
      CMD_ARM: begin
        if (pad_ok(item.pad)) begin
          learn_active_next = 1'b1;
          learn_target_next = item.pad;
        end else begin
          learn_active_next = 1'b0;
        end
      end
      CMD_CANCEL: learn_active_next = 1'b0;
      default: ;
    endcase
  end

  // write back: clear old partners of both note and pad, set the new pair
  always_comb begin
    wr.en          = busy && do_bind;
    wr.note        = item.note;
    wr.pad         = bind_pad;
    wr.clr_note_en = rd.pad_vld;
    wr.clr_note    = rd.pad_note;
    wr.clr_pad_en  = rd.note_vld;
    wr.clr_pad     = rd.note_pad;
  end

  // result fields
  always_comb begin
    rsp_next             = '0;
    rsp_next.learn_armed = learn_active_next;
    if (item.cmd == CMD_NOTE_ON) begin
      if (learn_hit) begin
        rsp_next.pad_out   = bind_pad;
        rsp_next.pad_valid = 1'b1;
        rsp_next.learned   = 1'b1;
      end else if (rd.note_vld) begin
        rsp_next.pad_out   = rd.note_pad;
        rsp_next.pad_valid = 1'b1;
      end
    end
  end

  // control and learn state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      done         <= 1'b0;
      learn_active <= 1'b0;
      learn_target <= '0;
    end else begin
      busy <= accept;
      done <= busy;
      if (busy) begin
        learn_active <= learn_active_next;
        learn_target <= learn_target_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (busy) rsp <= rsp_next;
  end

`ifndef NO_ASSERTIONS
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy) else $error("busy held longer than one cycle");

  a_done_follows_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> done) else $error("no result after work cycle");

  a_done_only_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without work cycle");

  a_learned_valid: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.learned) |-> (rsp.pad_valid && !rsp.learn_armed))
    else $error("learned note without pad or with capture still armed");
`endif

endmodule

FILE: rtl/core/ntpr_tables.sv
// ntpr_tables: note to pad and pad to note memories with per-entry valid flops
// depends on ntpr_pkg
module ntpr_tables
  import ntpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [NOTE_W-1:0] rd_note,
  input  logic [PAD_W-1:0]  rd_pad,
  output tbl_rd_t           rd,
  input  tbl_wr_t           wr
);

  logic [PAD_W-1:0]  note_mem [NOTE_COUNT];
  logic [NOTE_W-1:0] pad_mem  [PAD_COUNT];
  logic [NOTE_COUNT-1:0] note_valid;
  logic [PAD_COUNT-1:0]  pad_valid;

  // data memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr.en) begin
      note_mem[wr.note]        <= wr.pad;
      pad_mem[pad_idx(wr.pad)] <= wr.note;
    end
    // valid bits read alongside the data
    if (rd_en) begin
      rd.note_pad <= note_mem[rd_note];
      rd.pad_note <= pad_mem[pad_idx(rd_pad)];
      rd.note_vld <= note_valid[rd_note];
      rd.pad_vld  <= pad_valid[pad_idx(rd_pad)];
    end
  end

  // valid flops: drop stale partners, then set the new pair
  always_ff @(posedge clk) begin
    if (rst) begin
      note_valid <= '0;
      pad_valid  <= '0;
    end else if (wr.en) begin
      if (wr.clr_note_en) note_valid[wr.clr_note] <= 1'b0;
      if (wr.clr_pad_en)  pad_valid[pad_idx(wr.clr_pad)] <= 1'b0;
      note_valid[wr.note]         <= 1'b1;
      pad_valid[pad_idx(wr.pad)]  <= 1'b1;
    end
  end

endmodule

FILE: dv/note_to_pad_router_with_learn_unit_tb.sv
// note_to_pad_router_with_learn_unit_tb: self-checking bench for the note to pad router
// drives commands with random gaps, mirrors both routing tables and checks every response
// depends on ntpr_pkg and note_to_pad_router_with_learn_unit
`timescale 1ns / 100ps

module note_to_pad_router_with_learn_unit_tb;
  import ntpr_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  // mirrored routing state
  logic              note_vld [NOTE_COUNT];
  logic [PAD_W-1:0]  note_pad [NOTE_COUNT];
  logic              pad_vld  [PAD_COUNT];
  logic [NOTE_W-1:0] pad_note [PAD_COUNT];
  logic              armed;
  logic [PAD_W-1:0]  armed_pad;

  rsp_t route_q[$];
  int   errors  = 0;
  bit   gaps_on = 1'b1;

  note_to_pad_router_with_learn_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bind a note and a pad, dropping any older partner of either
  function automatic void pair_note_pad(input logic [NOTE_W-1:0] n,
                                        input logic [PAD_W-1:0] p);
    if (note_vld[n]) begin
      if (int'(note_pad[n]) < PAD_COUNT) pad_vld[note_pad[n]] = 1'b0;
      note_vld[n] = 1'b0;
    end
    if (pad_vld[p]) begin
      note_vld[pad_note[p]] = 1'b0;
      pad_vld[p] = 1'b0;
    end
    note_vld[n] = 1'b1;
    note_pad[n] = p;
    pad_vld[p]  = 1'b1;
    pad_note[p] = n;
  endfunction

  // expected response of one accepted command, updating the mirrored tables
  function automatic rsp_t route_note(input req_t r);
    rsp_t o;
    o = '0;
    case (r.cmd)
      CMD_NOTE_ON: begin
        if (armed && int'(armed_pad) < PAD_COUNT) begin
          pair_note_pad(r.note, armed_pad);
          armed       = 1'b0;
          o.pad_out   = armed_pad;
          o.pad_valid = 1'b1;
          o.learned   = 1'b1;
        end else if (note_vld[r.note]) begin
          o.pad_out   = note_pad[r.note];
          o.pad_valid = 1'b1;
        end
      end
      CMD_ARM: begin
        if (int'(r.pad) < PAD_COUNT) begin
          armed     = 1'b1;
          armed_pad = r.pad;
        end else begin
          armed = 1'b0;
        end
      end
      CMD_CANCEL: armed = 1'b0;
      default: begin
        if (int'(r.pad) < PAD_COUNT) pair_note_pad(r.note, r.pad);
      end
    endcase
    o.learn_armed = armed;
    return o;
  endfunction

  // mostly notes near the loaded map so lookups hit, sometimes any note
  function automatic logic [NOTE_W-1:0] pick_note();
    if ($urandom_range(3) == 0) return NOTE_W'($urandom_range(NOTE_COUNT - 1));
    return NOTE_W'(36 + $urandom_range(23));
  endfunction

  // send one item, with an optional gap first, and record its expected response
  task automatic send_item(input cmd_t c, input logic [NOTE_W-1:0] n,
                           input logic [PAD_W-1:0] p);
    req_t r;
    r.cmd  = c;
    r.note = n;
    r.pad  = p;
    if (gaps_on && $urandom_range(99) < 22) begin
      start <= 1'b0;
      req   <= req_t'($urandom);
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    route_q.push_back(route_note(r));
  endtask

  // extremes, every command and the learn corner cases
  task automatic test_directed();
    send_item(CMD_NOTE_ON, 7'd0,   4'd0);   // unmapped note
    send_item(CMD_NOTE_ON, 7'd127, 4'd15);
    send_item(CMD_CANCEL,  7'd127, 4'd15);  // cancel while idle
    send_item(CMD_ASSIGN,  7'd0,   4'd0);
    send_item(CMD_ASSIGN,  7'd127, 4'd15);
    send_item(CMD_NOTE_ON, 7'd0,   4'd7);
    send_item(CMD_NOTE_ON, 7'd127, 4'd0);
    send_item(CMD_ASSIGN,  7'd127, 4'd15);  // same binding again
    send_item(CMD_NOTE_ON, 7'd127, 4'd3);
    send_item(CMD_ARM,     7'd11,  4'd5);
    send_item(CMD_ARM,     7'd100, 4'd9);   // re-arm replaces target
    send_item(CMD_NOTE_ON, 7'd0,   4'd0);   // learn moves note 0 to pad 9
    send_item(CMD_NOTE_ON, 7'd0,   4'd0);
    send_item(CMD_ASSIGN,  7'd64,  4'd0);
    send_item(CMD_ARM,     7'd1,   4'd3);
    send_item(CMD_CANCEL,  7'd2,   4'd6);
    send_item(CMD_NOTE_ON, 7'd127, 4'd0);   // not captured after cancel
    send_item(CMD_ASSIGN,  7'd127, 4'd9);   // steals pad from note 0
    send_item(CMD_NOTE_ON, 7'd0,   4'd0);
    send_item(CMD_NOTE_ON, 7'd127, 4'd0);
    send_item(CMD_ARM,     7'd0,   4'd9);
    send_item(CMD_NOTE_ON, 7'd127, 4'd2);   // learn of the existing pairing
    send_item(CMD_ARM,     7'd0,   4'd15);
    send_item(CMD_NOTE_ON, 7'd64,  4'd1);   // note moves from pad 0 to pad 15
    send_item(CMD_NOTE_ON, 7'd64,  4'd1);
  endtask

  // default map loaded through assigns
  task automatic test_load_map();
    for (int p = 0; p < PAD_COUNT; p++) begin
      send_item(CMD_ASSIGN, NOTE_W'(36 + p), PAD_W'(p));
    end
  endtask

  // random mix of all commands
  task automatic test_random_traffic(input int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        send_item(CMD_NOTE_ON, pick_note(), PAD_W'($urandom));
      end else if (roll < 60) begin
        send_item(CMD_ARM, NOTE_W'($urandom), PAD_W'($urandom));
      end else if (roll < 68) begin
        send_item(CMD_CANCEL, NOTE_W'($urandom), PAD_W'($urandom));
      end else begin
        send_item(CMD_ASSIGN, pick_note(), PAD_W'($urandom));
      end
    end
  endtask

  // arm then capture a note, with some re-arms and broken sequences
  task automatic test_learn_sequences(input int count);
    int                roll;
    logic [NOTE_W-1:0] n;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      n    = pick_note();
      send_item(CMD_ARM, NOTE_W'($urandom), PAD_W'($urandom));
      if (roll < 20) begin
        send_item(CMD_ARM, NOTE_W'($urandom), PAD_W'($urandom));
      end else if (roll < 30) begin
        send_item(CMD_CANCEL, NOTE_W'($urandom), PAD_W'($urandom));
      end else if (roll >= 90) begin
        send_item(CMD_ASSIGN, pick_note(), PAD_W'($urandom));
      end
      send_item(CMD_NOTE_ON, n, PAD_W'($urandom));
      send_item(CMD_NOTE_ON, n, PAD_W'($urandom));
    end
  endtask

  function automatic void check_field(input string name, input logic [PAD_W-1:0] want,
                                      input logic [PAD_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // compare each response with the oldest expectation
  always @(negedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (route_q.size() == 0) begin
        errors++;
        $display("%0t: response with nothing pending, expected none, actual %p", $time, rsp);
      end else begin
        want = route_q.pop_front();
        check_field("pad_out",     want.pad_out,     rsp.pad_out);
        check_field("pad_valid",   PAD_W'(want.pad_valid),   PAD_W'(rsp.pad_valid));
        check_field("learned",     PAD_W'(want.learned),     PAD_W'(rsp.learned));
        check_field("learn_armed", PAD_W'(want.learn_armed), PAD_W'(rsp.learn_armed));
      end
    end
  end

  initial begin
    int waited;
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      note_vld[i] = 1'b0;
      note_pad[i] = '0;
    end
    for (int i = 0; i < PAD_COUNT; i++) begin
      pad_vld[i]  = 1'b0;
      pad_note[i] = '0;
    end
    armed     = 1'b0;
    armed_pad = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_load_map();
    test_random_traffic(700);
    test_learn_sequences(100);
    // long stretch with back-to-back items
    gaps_on = 1'b0;
    test_random_traffic(300);
    gaps_on = 1'b1;
    test_random_traffic(280);
    start <= 1'b0;

    // drain outstanding responses
    waited = 0;
    while (route_q.size() != 0 && waited < 50) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (route_q.size() != 0) begin
      errors++;
      $display("%0t: %0d responses missing, expected %p, actual none", $time,
               route_q.size(), route_q[0]);
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
